### rtl/core/smab_pkg.sv
`timescale 1ns / 1ps
package smab_pkg;

  localparam int NSTAGE = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  // ceil(2^32 / 255), exact quotient for dividends up to 255^3
  localparam logic [24:0] DIV255_RECIP = 25'd16843010;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_MODE  = 2'd0,
    CFG_CONST_ALPHA = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    MODE_BLEND     = 1'b0,
    MODE_COMPOSITE = 1'b1
  } blend_mode_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } pipe_ctl_t;

  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [48:0] prod;
    prod = {25'd0, x} * {24'd0, DIV255_RECIP};
    return prod[47:32];
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] v);
    return (v > {8'd0, FULL_SCALE}) ? FULL_SCALE : v[7:0];
  endfunction

endpackage

### rtl/core/smab_cfg.sv
`timescale 1ns / 1ps
module smab_cfg
  import smab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output blend_mode_t          blend_mode,
  output logic [7:0]           constant_alpha
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode     <= MODE_BLEND;
      constant_alpha <= FULL_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLEND_MODE:  blend_mode <= blend_mode_t'(cfg_data[0]);
        CFG_CONST_ALPHA: constant_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/smab_pipe_ctrl.sv
`timescale 1ns / 1ps
module smab_pipe_ctrl
  import smab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] adv;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTAGE-1] = !valid[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = valid[NSTAGE-1];
  assign ctl.load  = adv;
  assign ctl.valid = valid;

endmodule

### rtl/core/smab_datapath.sv
`timescale 1ns / 1ps
module smab_datapath
  import smab_pkg::*;
(
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  blend_mode_t blend_mode,
  input  logic [7:0]  constant_alpha,
  input  logic [7:0]  src_c0,
  input  logic [7:0]  src_c1,
  input  logic [7:0]  src_c2,
  input  logic [7:0]  src_alpha,
  input  logic [7:0]  dst_c0,
  input  logic [7:0]  dst_c1,
  input  logic [7:0]  dst_c2,
  input  logic [7:0]  dst_alpha,
  input  logic [7:0]  light_c0,
  input  logic [7:0]  light_c1,
  input  logic [7:0]  light_c2,
  output logic [7:0]  out_c0,
  output logic [7:0]  out_c1,
  output logic [7:0]  out_c2,
  output logic [7:0]  out_alpha
);

  logic [7:0] src_in [3];
  logic [7:0] dst_in [3];
  logic [7:0] lit_in [3];

  assign src_in[0] = src_c0;
  assign src_in[1] = src_c1;
  assign src_in[2] = src_c2;
  assign dst_in[0] = dst_c0;
  assign dst_in[1] = dst_c1;
  assign dst_in[2] = dst_c2;
  assign lit_in[0] = light_c0;
  assign lit_in[1] = light_c1;
  assign lit_in[2] = light_c2;

  // stage 1: products of input bytes
  blend_mode_t s1_mode;
  logic [15:0] s1_asrc;
  logic [15:0] s1_sl   [3];
  logic [15:0] s1_comp [3];
  logic [7:0]  s1_src_a;
  logic [7:0]  s1_dst  [3];
  logic [7:0]  s1_dst_a;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_mode  <= blend_mode;
      s1_asrc  <= {8'd0, src_alpha} * {8'd0, constant_alpha};
      s1_src_a <= src_alpha;
      s1_dst_a <= dst_alpha;
      for (int k = 0; k < 3; k++) begin
        s1_sl[k]   <= {8'd0, src_in[k]} * {8'd0, lit_in[k]};
        s1_comp[k] <= {8'd0, dst_in[k]} * {8'd0, light_c0};
        s1_dst[k]  <= dst_in[k];
      end
    end
  end

  // stage 2: effective alpha and composite channels
  blend_mode_t s2_mode;
  logic [7:0]  s2_a;
  logic [15:0] s2_sl    [3];
  logic [7:0]  s2_compq [3];
  logic [7:0]  s2_src_a;
  logic [7:0]  s2_dst   [3];
  logic [7:0]  s2_dst_a;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_mode  <= s1_mode;
      s2_a     <= 8'(div255({8'd0, s1_asrc}));
      s2_src_a <= s1_src_a;
      s2_dst_a <= s1_dst_a;
      for (int k = 0; k < 3; k++) begin
        s2_sl[k]    <= s1_sl[k];
        s2_compq[k] <= 8'(div255({8'd0, s1_comp[k]}));
        s2_dst[k]   <= s1_dst[k];
      end
    end
  end

  // stage 3: weight source and destination
  logic [7:0] s2_b;
  assign s2_b = FULL_SCALE - s2_a;

  blend_mode_t s3_mode;
  logic [23:0] s3_p     [3];
  logic [15:0] s3_db    [3];
  logic [15:0] s3_pa;
  logic [15:0] s3_pd;
  logic [7:0]  s3_compq [3];
  logic [7:0]  s3_dst_a;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_mode  <= s2_mode;
      s3_pa    <= {8'd0, s2_src_a} * {8'd0, s2_a};
      s3_pd    <= {8'd0, s2_dst_a} * {8'd0, s2_b};
      s3_dst_a <= s2_dst_a;
      for (int k = 0; k < 3; k++) begin
        s3_p[k]     <= {8'd0, s2_sl[k]} * {16'd0, s2_a};
        s3_db[k]    <= {8'd0, s2_dst[k]} * {8'd0, s2_b};
        s3_compq[k] <= s2_compq[k];
      end
    end
  end

  // stage 4: scale the lit source and sum the alpha terms
  blend_mode_t s4_mode;
  logic [15:0] s4_q     [3];
  logic [15:0] s4_db    [3];
  logic [16:0] s4_as;
  logic [7:0]  s4_compq [3];
  logic [7:0]  s4_dst_a;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_mode  <= s3_mode;
      s4_as    <= {1'b0, s3_pa} + {1'b0, s3_pd};
      s4_dst_a <= s3_dst_a;
      for (int k = 0; k < 3; k++) begin
        s4_q[k]     <= div255(s3_p[k]);
        s4_db[k]    <= s3_db[k];
        s4_compq[k] <= s3_compq[k];
      end
    end
  end

  // stage 5: sum the blend terms
  blend_mode_t s5_mode;
  logic [16:0] s5_s     [3];
  logic [16:0] s5_as;
  logic [7:0]  s5_compq [3];
  logic [7:0]  s5_dst_a;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_mode  <= s4_mode;
      s5_as    <= s4_as;
      s5_dst_a <= s4_dst_a;
      for (int k = 0; k < 3; k++) begin
        s5_s[k]     <= {1'b0, s4_q[k]} + {1'b0, s4_db[k]};
        s5_compq[k] <= s4_compq[k];
      end
    end
  end

  // stage 6: final divide, clamp and mode select
  logic [7:0] blend_c [3];
  logic [7:0] blend_a;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend_c[k] = sat8(div255({7'd0, s5_s[k]}));
    end
    blend_a = sat8(div255({7'd0, s5_as}));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      if (s5_mode == MODE_COMPOSITE) begin
        out_c0    <= s5_compq[0];
        out_c1    <= s5_compq[1];
        out_c2    <= s5_compq[2];
        out_alpha <= s5_dst_a;
      end else begin
        out_c0    <= blend_c[0];
        out_c1    <= blend_c[1];
        out_c2    <= blend_c[2];
        out_alpha <= blend_a;
      end
    end
  end

endmodule

### rtl/core/shadow_modulated_alpha_blend_top.sv
`timescale 1ns / 1ps
// throughput: one word per cycle while out_stall is low, through the six-stage multiply/divide pipeline
// output stall backs up through the stages; input stall only when all stages hold words
// reset: synchronous, clears all stage valid bits, blend_mode to blend, constant_alpha to 255
module shadow_modulated_alpha_blend_top
  import smab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           src_c0,
  input  logic [7:0]           src_c1,
  input  logic [7:0]           src_c2,
  input  logic [7:0]           src_alpha,
  input  logic [7:0]           dst_c0,
  input  logic [7:0]           dst_c1,
  input  logic [7:0]           dst_c2,
  input  logic [7:0]           dst_alpha,
  input  logic [7:0]           light_c0,
  input  logic [7:0]           light_c1,
  input  logic [7:0]           light_c2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_c0,
  output logic [7:0]           out_c1,
  output logic [7:0]           out_c2,
  output logic [7:0]           out_alpha
);

  blend_mode_t blend_mode;
  logic [7:0]  constant_alpha;
  pipe_ctl_t   ctl;

  smab_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .blend_mode     (blend_mode),
    .constant_alpha (constant_alpha)
  );

  smab_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  smab_datapath u_dp (
    .clk            (clk),
    .ctl            (ctl),
    .blend_mode     (blend_mode),
    .constant_alpha (constant_alpha),
    .src_c0         (src_c0),
    .src_c1         (src_c1),
    .src_c2         (src_c2),
    .src_alpha      (src_alpha),
    .dst_c0         (dst_c0),
    .dst_c1         (dst_c1),
    .dst_c2         (dst_c2),
    .dst_alpha      (dst_alpha),
    .light_c0       (light_c0),
    .light_c1       (light_c1),
    .light_c2       (light_c2),
    .out_c0         (out_c0),
    .out_c1         (out_c1),
    .out_c2         (out_c2),
    .out_alpha      (out_alpha)
  );

  a_no_input_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&ctl.valid))
    else $error("input stalled with an empty pipeline stage");

  a_cfg_reset_values: assert property (@(posedge clk)
    rst |=> (blend_mode == MODE_BLEND) && (constant_alpha == FULL_SCALE))
    else $error("configuration registers not at reset values");

  a_valid_follows_stage: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid[NSTAGE-2] && ctl.load[NSTAGE-1]) |=> out_valid)
    else $error("word lost between last two stages");

endmodule

### bench/blend_checker.sv
`timescale 1ns / 1ps
module blend_checker
  import smab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           src_c0,
  input  logic [7:0]           src_c1,
  input  logic [7:0]           src_c2,
  input  logic [7:0]           src_alpha,
  input  logic [7:0]           dst_c0,
  input  logic [7:0]           dst_c1,
  input  logic [7:0]           dst_c2,
  input  logic [7:0]           dst_alpha,
  input  logic [7:0]           light_c0,
  input  logic [7:0]           light_c1,
  input  logic [7:0]           light_c2,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_c0,
  input  logic [7:0]           out_c1,
  input  logic [7:0]           out_c2,
  input  logic [7:0]           out_alpha,
  output int                   errors,
  output int                   pending
);

  localparam int unsigned SCALE = 255;

  // byte 3 is alpha, bytes 0..2 are the color channels
  typedef logic [3:0][7:0] rgba_t;

  blend_mode_t mode_q;
  logic [7:0]  alpha_q;
  rgba_t       expected_pixels[$];
  int          fail_tally = 0;

  function automatic rgba_t shade_pixel(input rgba_t src, input rgba_t dst,
                                        input logic [2:0][7:0] lit,
                                        input blend_mode_t mode,
                                        input logic [7:0] const_alpha);
    rgba_t       res;
    int unsigned a;
    int unsigned b;
    int unsigned v;
    if (mode == MODE_BLEND) begin
      a = src[3] * const_alpha / SCALE;
      b = SCALE - a;
      for (int k = 0; k < 3; k++) begin
        v = (src[k] * lit[k] * a / SCALE + dst[k] * b) / SCALE;
        res[k] = (v > SCALE) ? 8'hFF : v[7:0];
      end
      v = (src[3] * a + dst[3] * b) / SCALE;
      res[3] = (v > SCALE) ? 8'hFF : v[7:0];
    end else begin
      for (int k = 0; k < 3; k++) begin
        v = dst[k] * lit[0] / SCALE;
        res[k] = (v > SCALE) ? 8'hFF : v[7:0];
      end
      res[3] = dst[3];
    end
    return res;
  endfunction

  task automatic log_miss(input string msg);
    fail_tally++;
    if (fail_tally <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (rst) begin
      mode_q  <= MODE_BLEND;
      alpha_q <= 8'd255;
      expected_pixels.delete();
      pending <= 0;
      errors  <= fail_tally;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_alpha, out_c2, out_c1, out_c0};
        if (expected_pixels.size() == 0) begin
          log_miss($sformatf("output word %h with no input word pending", got));
        end else begin
          want = expected_pixels.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k])
              log_miss($sformatf("%s mismatch: expected %0d, got %0d",
                                 (k == 3) ? "out_alpha" : $sformatf("out_c%0d", k),
                                 want[k], got[k]));
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.insert(expected_pixels.size(), shade_pixel(
          {src_alpha, src_c2, src_c1, src_c0},
          {dst_alpha, dst_c2, dst_c1, dst_c0},
          {light_c2, light_c1, light_c0}, mode_q, alpha_q));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLEND_MODE:  mode_q <= blend_mode_t'(cfg_data[0]);
          CFG_CONST_ALPHA: alpha_q <= cfg_data;
          default: ;
        endcase
      end
      pending <= expected_pixels.size();
      errors  <= fail_tally;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import smab_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0] src_c0;
    logic [7:0] src_c1;
    logic [7:0] src_c2;
    logic [7:0] src_alpha;
    logic [7:0] dst_c0;
    logic [7:0] dst_c1;
    logic [7:0] dst_c2;
    logic [7:0] dst_alpha;
    logic [7:0] light_c0;
    logic [7:0] light_c1;
    logic [7:0] light_c2;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           src_c0 = '0, src_c1 = '0, src_c2 = '0, src_alpha = '0;
  logic [7:0]           dst_c0 = '0, dst_c1 = '0, dst_c2 = '0, dst_alpha = '0;
  logic [7:0]           light_c0 = '0, light_c1 = '0, light_c2 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_c0, out_c1, out_c2, out_alpha;
  int                   errors;
  int                   pending;
  int                   stall_pct = 0;
  int                   gap_pct = 0;
  int                   quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  shadow_modulated_alpha_blend_top dut (.*);

  blend_checker checker_i (.*);

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(48, 16);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.src_c0    = rand_byte();
    p.src_c1    = rand_byte();
    p.src_c2    = rand_byte();
    p.src_alpha = rand_byte();
    p.dst_c0    = rand_byte();
    p.dst_c1    = rand_byte();
    p.dst_c2    = rand_byte();
    p.dst_alpha = rand_byte();
    p.light_c0  = rand_byte();
    p.light_c1  = rand_byte();
    p.light_c2  = rand_byte();
    return p;
  endfunction

  function automatic pixel_t flat_pixel(input logic [7:0] v);
    return {11{v}};
  endfunction

  task automatic drive_pixel(input pixel_t p);
    in_valid  <= 1'b1;
    src_c0    <= p.src_c0;
    src_c1    <= p.src_c1;
    src_c2    <= p.src_c2;
    src_alpha <= p.src_alpha;
    dst_c0    <= p.dst_c0;
    dst_c1    <= p.dst_c1;
    dst_c2    <= p.dst_c2;
    dst_alpha <= p.dst_alpha;
    light_c0  <= p.light_c0;
    light_c1  <= p.light_c1;
    light_c2  <= p.light_c2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits of the mode write are noise
  task automatic configure(input blend_mode_t mode, input logic [7:0] alpha);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, rand_byte());
    write_reg(CFG_BLEND_MODE, {7'($urandom), mode});
    write_reg(CFG_CONST_ALPHA, alpha);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        n = idle_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("shadow_modulated_alpha_blend_top regression: fail");
      $finish;
    end
  end

  initial begin
    pixel_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset config: blend, full constant alpha
    drive_pixel(flat_pixel(8'h00));
    drive_pixel(flat_pixel(8'hFF));
    drive_pixel(flat_pixel(8'hAA));
    drive_pixel(flat_pixel(8'h55));
    p = random_pixel();
    p.src_alpha = 8'h00;
    drive_pixel(p);
    p = random_pixel();
    p.src_alpha = 8'hFF;
    drive_pixel(p);
    p = random_pixel();
    {p.light_c0, p.light_c1, p.light_c2} = '0;
    drive_pixel(p);
    p = random_pixel();
    {p.light_c0, p.light_c1, p.light_c2, p.src_alpha} = '1;
    drive_pixel(p);
    p = flat_pixel(8'hFF);
    {p.dst_c0, p.dst_c1, p.dst_c2, p.dst_alpha} = '0;
    drive_pixel(p);
    p = flat_pixel(8'hFF);
    {p.src_c0, p.src_c1, p.src_c2} = '0;
    drive_pixel(p);
    wait_idle();

    configure(MODE_COMPOSITE, 8'd255);
    drive_pixel(flat_pixel(8'hFF));
    p = random_pixel();
    p.light_c0 = 8'h00;
    drive_pixel(p);
    p = random_pixel();
    p.light_c0 = 8'hFF;
    drive_pixel(p);
    drive_pixel(random_pixel());
    wait_idle();

    configure(MODE_BLEND, 8'd0);
    drive_pixel(flat_pixel(8'hFF));
    drive_pixel(random_pixel());
    wait_idle();

    configure(MODE_BLEND, 8'd128);
    write_reg(CFG_SPARE_2, 8'hFF);
    write_reg(CFG_SPARE_3, 8'h00);
    cfg_valid <= 1'b0;
    drive_pixel(random_pixel());
    drive_pixel(flat_pixel(8'hFF));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       configure(MODE_BLEND, 8'd255);
        1:       configure(MODE_BLEND, 8'd0);
        2:       configure(MODE_COMPOSITE, rand_byte());
        3:       configure(MODE_BLEND, 8'd1);
        4:       configure(MODE_BLEND, 8'd254);
        default: configure(blend_mode_t'($urandom_range(1)), rand_byte());
      endcase
      if (ph == 0) begin
        stall_pct = 0;
        gap_pct = 0;
      end else begin
        stall_pct = 20 * $urandom_range(3);
        gap_pct = 20 * $urandom_range(3);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        drive_pixel(random_pixel());
        if (ph == 6 && i == PHASE_ITEMS / 2)
          wait_idle();
        else
          sender_gap();
      end
      wait_idle();
    end

    stall_pct = 0;
    repeat (NSTAGE + 4) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("shadow_modulated_alpha_blend_top regression: pass");
    else
      $display("shadow_modulated_alpha_blend_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/smab_pkg.sv
rtl/core/smab_cfg.sv
rtl/core/smab_pipe_ctrl.sv
rtl/core/smab_datapath.sv
rtl/core/shadow_modulated_alpha_blend_top.sv
bench/blend_checker.sv
bench/tb.sv
